[rtl/core/lcps_pkg.sv]
package lcps_pkg;

   // default cell width of the solver
   localparam int CELL_WIDTH_DEF = 32;

   // result status codes
   typedef enum logic [1:0] {
      ST_SOLVED = 2'd0,
      ST_NONE   = 2'd1,
      ST_ZERO_A = 2'd2
   } status_type;

   // flags that follow an item down the pipeline
   typedef struct packed {
      logic zero_a;   // a was zero after the cut to the cell width
      logic no_sol;   // reduced a even while reduced b odd
   } ctl_type;

endpackage

[rtl/core/linear_congruence_pow2_solver.sv]
// Solves a*x = b mod 2^CELL_WIDTH for each item. Common factors of two are
// removed from a and b (their count comes back as common_twos); if the reduced
// a is odd, x = inverse(a) * b wrapped, with status 0. An even reduced a with
// odd reduced b gives status 1, a zero a gives status 2 and zero twos, and
// the solution is 0 on any failure. Three stages find and shift out the
// trailing zeros, then one stage per bit of x (a CELL_WIDTH-bit subtract each)
// solves the congruence, then an output register. The pipeline takes one item
// per cycle while the output is not stalled; a stall holds each stage that
// is full, so the item rate does not depend on the depth of the chain.
module linear_congruence_pow2_solver
   import lcps_pkg::*;
#(
   parameter int CELL_WIDTH = CELL_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // coef_a [31:0], rhs_b [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata     // status [1:0], solution [33:2],
                                     // common_twos [38:34], zero [39]
);

   localparam int TW = $clog2(CELL_WIDTH);

   // bit-step chain, index 0 is the output of the trailing-zero stages
   logic                  v_c    [CELL_WIDTH+1];
   logic                  rdy_c  [CELL_WIDTH+1];
   logic [CELL_WIDTH-1:0] a_c    [CELL_WIDTH+1];
   logic [CELL_WIDTH-1:0] r_c    [CELL_WIDTH+1];
   logic [CELL_WIDTH-1:0] x_c    [CELL_WIDTH+1];
   logic [TW-1:0]         twos_c [CELL_WIDTH+1];
   ctl_type               ctl_c  [CELL_WIDTH+1];

   // output register
   logic        rsp_v_ff, rsp_v_in;
   logic [39:0] rsp_data_ff;
   status_type  status_in;
   logic [31:0] solution_in;
   logic [4:0]  twos_in;

   lcps_twos #(
      .CELL_WIDTH (CELL_WIDTH),
      .TW         (TW)
   ) u_twos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .coef_a    (req_tdata[31:0]),
      .rhs_b     (req_tdata[63:32]),
      .out_valid (v_c[0]),
      .out_ready (rdy_c[0]),
      .out_a     (a_c[0]),
      .out_b     (r_c[0]),
      .out_twos  (twos_c[0]),
      .out_ctl   (ctl_c[0])
   );

   assign x_c[0] = '0;

   // one stage per bit of the solution
   for (genvar i = 0; i < CELL_WIDTH; i++) begin : g_step
      lcps_bit_step #(
         .CELL_WIDTH (CELL_WIDTH),
         .TW         (TW)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v_c[i]),
         .in_ready  (rdy_c[i]),
         .in_a      (a_c[i]),
         .in_r      (r_c[i]),
         .in_x      (x_c[i]),
         .in_twos   (twos_c[i]),
         .in_ctl    (ctl_c[i]),
         .out_valid (v_c[i+1]),
         .out_ready (rdy_c[i+1]),
         .out_a     (a_c[i+1]),
         .out_r     (r_c[i+1]),
         .out_x     (x_c[i+1]),
         .out_twos  (twos_c[i+1]),
         .out_ctl   (ctl_c[i+1])
      );
   end

   // status and masking of the result
   always_comb begin
      if (ctl_c[CELL_WIDTH].zero_a) begin
         status_in = ST_ZERO_A;
      end else if (ctl_c[CELL_WIDTH].no_sol) begin
         status_in = ST_NONE;
      end else begin
         status_in = ST_SOLVED;
      end
   end

   // the final residual is not needed once all bits of x are known
   assign solution_in = (status_in == ST_SOLVED) ? 32'(x_c[CELL_WIDTH]) : 32'd0;
   assign twos_in     = ctl_c[CELL_WIDTH].zero_a ? 5'd0 : 5'(twos_c[CELL_WIDTH]);

   assign rdy_c[CELL_WIDTH] = ~rsp_v_ff | rsp_tready;
   assign rsp_v_in          = rdy_c[CELL_WIDTH] ? v_c[CELL_WIDTH] : rsp_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else begin
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_c[CELL_WIDTH] && v_c[CELL_WIDTH]) begin
         rsp_data_ff <= {1'b0, twos_in, solution_in, status_in};
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a failed item never carries a solution
   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != ST_SOLVED) |-> rsp_tdata[33:2] == 32'd0)
      else $error("nonzero solution on a failed item");

   // zero multiplier reports no twos
   a_zero_twos : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == ST_ZERO_A) |-> rsp_tdata[38:34] == 5'd0)
      else $error("twos reported for a zero multiplier");

   // only defined status codes leave the block
   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == ST_SOLVED) || (rsp_tdata[1:0] == ST_NONE)
                     || (rsp_tdata[1:0] == ST_ZERO_A))
      else $error("undefined status code");

   // an item reaching the end of the chain is taken once the output drains
   a_drain : assert property (@(posedge clock) disable iff (reset)
      v_c[CELL_WIDTH] && !rsp_tvalid |=> rsp_tvalid)
      else $error("result lost at the output register");

endmodule

[rtl/core/lcps_twos.sv]
module lcps_twos
   import lcps_pkg::*;
#(
   parameter int CELL_WIDTH = CELL_WIDTH_DEF,
   parameter int TW         = $clog2(CELL_WIDTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [31:0]           coef_a,
   input  logic [31:0]           rhs_b,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [CELL_WIDTH-1:0] out_a,
   output logic [CELL_WIDTH-1:0] out_b,
   output logic [TW-1:0]         out_twos,
   output ctl_type               out_ctl
);

   localparam int NB = (CELL_WIDTH + 7) / 8;
   localparam int PW = NB * 8;

   function automatic logic [2:0] byte_ctz(input logic [7:0] v);
      logic [2:0] r;
      r = '0;
      for (int k = 7; k >= 0; k--) begin
         if (v[k]) begin
            r = 3'(k);
         end
      end
      return r;
   endfunction

   // stage 1: cut to cell width, per-byte zero flags and trailing zeros
   logic [CELL_WIDTH-1:0] a_w, b_w;
   logic [PW-1:0]         or_p;
   logic                  s1_v_ff, s1_v_in, s1_rdy;
   logic [CELL_WIDTH-1:0] s1_a_ff, s1_b_ff;
   logic [NB-1:0]         s1_nz_ff, s1_nz_in;
   logic [2:0]            s1_ctz_ff [NB];
   logic [2:0]            s1_ctz_in [NB];
   logic                  s1_zero_ff;

   // stage 2: pick lowest nonzero byte
   logic                  s2_v_ff, s2_v_in, s2_rdy;
   logic [CELL_WIDTH-1:0] s2_a_ff, s2_b_ff;
   logic [TW-1:0]         s2_twos_ff, s2_twos_in;
   logic                  s2_zero_ff;

   // stage 3: shift out the common twos
   logic                  s3_v_ff, s3_v_in, s3_rdy;
   logic [CELL_WIDTH-1:0] s3_a_ff, s3_b_ff, a_red, b_red;
   logic [TW-1:0]         s3_twos_ff;
   ctl_type               s3_ctl_ff, s3_ctl_in;

   assign a_w  = CELL_WIDTH'(coef_a);
   assign b_w  = CELL_WIDTH'(rhs_b);
   assign or_p = PW'(a_w | b_w);

   always_comb begin
      for (int j = 0; j < NB; j++) begin
         s1_nz_in[j]  = |or_p[j*8 +: 8];
         s1_ctz_in[j] = byte_ctz(or_p[j*8 +: 8]);
      end
   end

   always_comb begin
      s2_twos_in = '0;
      for (int j = NB - 1; j >= 0; j--) begin
         if (s1_nz_ff[j]) begin
            s2_twos_in = TW'(8 * j + int'(s1_ctz_ff[j]));
         end
      end
   end

   assign a_red            = s2_a_ff >> s2_twos_ff;
   assign b_red            = s2_b_ff >> s2_twos_ff;
   assign s3_ctl_in.zero_a = s2_zero_ff;
   assign s3_ctl_in.no_sol = ~a_red[0];

   // handshake, each stage takes a new item when empty or moving on
   assign s3_rdy   = ~s3_v_ff | out_ready;
   assign s2_rdy   = ~s2_v_ff | s3_rdy;
   assign s1_rdy   = ~s1_v_ff | s2_rdy;
   assign in_ready = s1_rdy;

   assign s1_v_in = s1_rdy ? in_valid : s1_v_ff;
   assign s2_v_in = s2_rdy ? s1_v_ff  : s2_v_ff;
   assign s3_v_in = s3_rdy ? s2_v_ff  : s3_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy && in_valid) begin
         s1_a_ff    <= a_w;
         s1_b_ff    <= b_w;
         s1_nz_ff   <= s1_nz_in;
         s1_ctz_ff  <= s1_ctz_in;
         s1_zero_ff <= ~|a_w;
      end
      if (s2_rdy && s1_v_ff) begin
         s2_a_ff    <= s1_a_ff;
         s2_b_ff    <= s1_b_ff;
         s2_twos_ff <= s2_twos_in;
         s2_zero_ff <= s1_zero_ff;
      end
      if (s3_rdy && s2_v_ff) begin
         s3_a_ff    <= a_red;
         s3_b_ff    <= b_red;
         s3_twos_ff <= s2_twos_ff;
         s3_ctl_ff  <= s3_ctl_in;
      end
   end

   assign out_valid = s3_v_ff;
   assign out_a     = s3_a_ff;
   assign out_b     = s3_b_ff;
   assign out_twos  = s3_twos_ff;
   assign out_ctl   = s3_ctl_ff;

endmodule

[rtl/core/lcps_bit_step.sv]
module lcps_bit_step
   import lcps_pkg::*;
#(
   parameter int CELL_WIDTH = CELL_WIDTH_DEF,
   parameter int TW         = $clog2(CELL_WIDTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [CELL_WIDTH-1:0] in_a,
   input  logic [CELL_WIDTH-1:0] in_r,
   input  logic [CELL_WIDTH-1:0] in_x,
   input  logic [TW-1:0]         in_twos,
   input  ctl_type               in_ctl,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [CELL_WIDTH-1:0] out_a,
   output logic [CELL_WIDTH-1:0] out_r,
   output logic [CELL_WIDTH-1:0] out_x,
   output logic [TW-1:0]         out_twos,
   output ctl_type               out_ctl
);

   // residual r keeps b - a*x = 2^i * r; the next bit of x is r[0]
   logic                  x_bit;
   logic [CELL_WIDTH-1:0] diff, r_in, x_in;
   logic                  v_ff, v_in;
   logic [CELL_WIDTH-1:0] a_ff, r_ff, x_ff;
   logic [TW-1:0]         twos_ff;
   ctl_type               ctl_ff;

   assign x_bit = in_r[0];
   assign diff  = in_r - (x_bit ? in_a : '0);
   assign r_in  = {1'b0, diff[CELL_WIDTH-1:1]};
   // bits enter at the top and reach their place after the last step
   assign x_in  = {x_bit, in_x[CELL_WIDTH-1:1]};

   assign in_ready = ~v_ff | out_ready;
   assign v_in     = in_ready ? in_valid : v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         a_ff    <= in_a;
         r_ff    <= r_in;
         x_ff    <= x_in;
         twos_ff <= in_twos;
         ctl_ff  <= in_ctl;
      end
   end

   assign out_valid = v_ff;
   assign out_a     = a_ff;
   assign out_r     = r_ff;
   assign out_x     = x_ff;
   assign out_twos  = twos_ff;
   assign out_ctl   = ctl_ff;

endmodule

[verif/linear_congruence_pow2_solver_tb.sv]
module linear_congruence_pow2_solver_tb
   import lcps_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // one predicted result item
   typedef struct {
      status_type  status;
      logic [31:0] solution;
      logic [4:0]  twos;
   } congruence_answer_type;

   // predicts each answer and keeps the answers still owed by the block
   class solution_ledger;
      congruence_answer_type owed_answers[$];
      int unsigned           mismatches;
      int unsigned           answers_checked;
      int unsigned           status_seen[3];

      function new();
         mismatches      = 0;
         answers_checked = 0;
         status_seen     = '{0, 0, 0};
      endfunction

      // a*x = b mod 2^32: strip shared twos, then invert the odd multiplier
      function congruence_answer_type solve_pow2(logic [31:0] a, logic [31:0] b);
         congruence_answer_type ans;
         logic [31:0]           ra;
         logic [31:0]           rb;
         logic [31:0]           inv;
         ans.status   = ST_SOLVED;
         ans.solution = '0;
         ans.twos     = '0;
         ra           = a;
         rb           = b;
         if (ra == '0) begin
            ans.status = ST_ZERO_A;
            return ans;
         end
         while (!ra[0] && !rb[0]) begin
            ra       = ra >> 1;
            rb       = rb >> 1;
            ans.twos = ans.twos + 5'd1;
         end
         if (!ra[0]) begin
            ans.status = ST_NONE;
         end else begin
            // newton steps double the correct low bits: 3, 6, 12, 24, 48, 96
            inv = ra;
            repeat (5) inv = inv * (32'd2 - ra * inv);
            ans.solution = inv * rb;
         end
         return ans;
      endfunction

      function void note_request(logic [31:0] a, logic [31:0] b);
         owed_answers.push_back(solve_pow2(a, b));
      endfunction

      function void check_response(logic [39:0] data);
         congruence_answer_type want;
         logic [1:0]            got_status;
         logic [31:0]           got_solution;
         logic [4:0]            got_twos;
         got_status   = data[1:0];
         got_solution = data[33:2];
         got_twos     = data[38:34];
         if (owed_answers.size() == 0) begin
            $display("%0t: unexpected result item, expected none, got %h", $time, data);
            mismatches++;
            return;
         end
         want = owed_answers.pop_front();
         answers_checked++;
         if (want.status <= ST_ZERO_A) status_seen[want.status]++;
         if (got_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, got_status);
            mismatches++;
         end
         if (got_solution !== want.solution) begin
            $display("%0t: solution mismatch, expected %h, got %h",
                     $time, want.solution, got_solution);
            mismatches++;
         end
         if (got_twos !== want.twos) begin
            $display("%0t: common_twos mismatch, expected %0d, got %0d",
                     $time, want.twos, got_twos);
            mismatches++;
         end
      endfunction
   endclass

   // clock, reset and the two stream channels
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;     // coef_a [31:0], rhs_b [63:32]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // status [1:0], solution [33:2],
                                     // common_twos [38:34], zero [39]

   // idle percentages for each side, changed per phase by the stimulus
   int unsigned sender_gap_pct   = 30;
   int unsigned receiver_gap_pct = 69;
   int unsigned requests_sent    = 0;
   bit          long_hold_done   = 1'b0;

   solution_ledger ledger = new();

   linear_congruence_pow2_solver i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // offer one item, optionally after a short gap, and log it once accepted
   task automatic offer_operands(input logic [31:0] a, input logic [31:0] b);
      if ($urandom_range(99) < sender_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ledger.note_request(a, b);
      requests_sent++;
   endtask

   // receiver: checks accepted items, stalls at random, and once holds off
   // long enough for the pipeline to fill and push back on the input
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) ledger.check_response(rsp_tdata);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (!long_hold_done && ledger.answers_checked >= 150) begin
            long_hold_done = 1'b1;
            hold_left      = 399;
            rsp_tready     <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_gap_pct);
         end
      end
   end

   // stimulus
   initial begin
      logic [31:0] a;
      logic [31:0] b;
      int unsigned k;
      int unsigned j;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero multiplier, extremes, all-twos, no solution cases
      offer_operands(32'h0000_0000, 32'h0000_0000);
      offer_operands(32'h0000_0000, 32'hffff_ffff);
      offer_operands(32'h0000_0001, 32'h0000_0000);
      offer_operands(32'h0000_0001, 32'hffff_ffff);
      offer_operands(32'hffff_ffff, 32'hffff_ffff);
      offer_operands(32'hffff_ffff, 32'h0000_0001);
      offer_operands(32'h8000_0000, 32'h0000_0000);   // zero b: twos of a only
      offer_operands(32'h8000_0000, 32'h8000_0000);   // 31 shared twos
      offer_operands(32'h8000_0000, 32'h0000_0001);   // even a, odd b
      offer_operands(32'h0000_0002, 32'h0000_0003);
      offer_operands(32'h0000_0004, 32'h0000_0006);   // one shared two, still none
      offer_operands(32'h0000_0006, 32'h0000_0004);
      offer_operands(32'h0000_0003, 32'h0000_0000);
      offer_operands(32'h5555_5555, 32'haaaa_aaaa);
      offer_operands(32'haaaa_aaaa, 32'h5555_5555);
      offer_operands(32'h0000_000c, 32'h0000_0008);
      offer_operands(32'hffff_fffe, 32'hffff_fffe);
      offer_operands(32'h0000_0010, 32'h0000_0030);
      offer_operands(32'h0000_0007, 32'h0000_0001);
      offer_operands(32'h7fff_ffff, 32'h8000_0000);

      // random phases: sender 30/receiver 69, then swapped, then no idling
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_gap_pct   = 30;
               receiver_gap_pct = 69;
            end
            1: begin
               sender_gap_pct   = 69;
               receiver_gap_pct = 30;
            end
            default: begin
               sender_gap_pct   = 0;
               receiver_gap_pct = 0;
            end
         endcase
         for (int n = 0; n < 567; n++) begin
            case ($urandom_range(9))
               0: begin
                  a = '0;
                  b = $urandom;
               end
               1, 2: begin
                  a = $urandom;
                  b = $urandom;
               end
               3, 4: begin
                  // shared twos, solvable
                  k = $urandom_range(31);
                  a = ($urandom | 32'd1) << k;
                  b = $urandom << k;
               end
               5: begin
                  a = $urandom | 32'd1;
                  b = $urandom;
               end
               6: begin
                  // a holds more twos than b: no solution after k removals
                  k = $urandom_range(30);
                  j = $urandom_range(k + 1, 31);
                  a = ($urandom | 32'd1) << j;
                  b = ($urandom | 32'd1) << k;
               end
               7: begin
                  a = $urandom;
                  b = '0;
               end
               8: begin
                  a = 32'd1 << $urandom_range(31);
                  b = $urandom;
               end
               default: begin
                  // operands close to all ones
                  a = ~($urandom & $urandom & $urandom);
                  b = ~($urandom & $urandom);
               end
            endcase
            offer_operands(a, b);
         end
      end
      req_tvalid <= 1'b0;

      // drain, then watch a little longer for stray items
      while (ledger.owed_answers.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("%0d items checked: %0d solved, %0d without solution, %0d zero multiplier",
               ledger.answers_checked, ledger.status_seen[ST_SOLVED],
               ledger.status_seen[ST_NONE], ledger.status_seen[ST_ZERO_A]);
      $display("idling on both sides, one long output stall, back-to-back phase");
      if (ledger.mismatches == 0) begin
         $display("linear_congruence_pow2_solver test passed");
      end else begin
         $display("linear_congruence_pow2_solver test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("linear_congruence_pow2_solver test failed");
      $finish;
   end

endmodule
